>>> design/rss_pkg.sv
// Shared types, constants, microcode program and angle table for the sector selector.
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int MAX_ITEMS    = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int Z_BITS       = 32;

    localparam int IDX_BITS     = 5;
    localparam int CNT_BITS     = 6;
    localparam int DZ_BITS      = 12;
    localparam int MASK_BITS    = 32;
    localparam int REG_IDX_BITS = 2;
    localparam int CMD_BITS     = 2;
    localparam int EV_BITS      = 2;

    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * DIFF_BITS;
    localparam int RSQ_BITS     = 2 * DZ_BITS;
    localparam int CORD_BITS    = COORD_BITS + 4;
    localparam int SCALE_BITS   = ANGLE_BITS + CNT_BITS;

    // two vectoring iterations per loop step
    localparam int ITERS        = CORDIC_STEPS / 2;
    localparam int ITER_BITS    = 4;
    localparam int SH_BITS      = ITER_BITS + 1;
    localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(ITERS - 1);

    localparam logic [CMD_BITS-1:0] CMD_SHOW = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_HIDE = 2'd2;

    localparam logic [EV_BITS-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_BITS-1:0] EV_SHOW  = 2'd1;
    localparam logic [EV_BITS-1:0] EV_HOVER = 2'd2;
    localparam logic [EV_BITS-1:0] EV_HIDE  = 2'd3;

    localparam logic [REG_IDX_BITS-1:0] REG_DEADZONE = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_COUNT    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MASK     = 2'd2;

    localparam logic [DZ_BITS-1:0]   DZ_RESET    = '0;
    localparam logic [CNT_BITS-1:0]  CNT_RESET   = 6'd8;
    localparam logic [MASK_BITS-1:0] MASK_RESET  = '1;

    typedef logic [3:0] step_t;

    localparam step_t S_FETCH    = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_CHECK    = 4'd2;
    localparam step_t S_DIFF     = 4'd3;
    localparam step_t S_SQX      = 4'd4;
    localparam step_t S_SQY      = 4'd5;
    localparam step_t S_CINIT    = 4'd6;
    localparam step_t S_CSTEP    = 4'd7;
    localparam step_t S_SCALE    = 4'd8;
    localparam step_t S_INDEX    = 4'd9;
    localparam step_t S_CMP      = 4'd10;
    localparam step_t S_HOVER    = 4'd11;
    localparam step_t S_HIDE     = 4'd12;
    localparam step_t S_SHOW     = 4'd13;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_CINIT,
        OP_CSTEP,
        OP_SCALE,
        OP_INDEX,
        OP_HOVER,
        OP_HIDE,
        OP_SHOW
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_SHOW,
        C_SKIP,
        C_HIDE,
        C_INSIDE,
        C_MORE,
        C_SAME
    } cond_t;

    typedef struct packed {
        logic   wait_in;
        logic   emit;
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ucode_t;

    typedef struct packed {
        logic   exec;
        logic   load;
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic cmd_show;
        logic cmd_hide;
        logic skip;
        logic in_dead;
        logic more;
        logic same;
    } stat_t;

    typedef struct packed {
        logic [EV_BITS-1:0]  event_res;
        logic                hover_valid;
        logic [IDX_BITS-1:0] hover_index;
        logic                selected;
        logic [IDX_BITS-1:0] selected_index;
    } res_t;

    function automatic ucode_t ucode(input step_t s);
        ucode_t w;
        w = '{wait_in: 1'b0, emit: 1'b0, op: OP_NONE, cond: C_NEXT, target: S_FETCH};
        case (s)
            S_FETCH:
            begin
                w.wait_in = 1'b1;
                w.op      = OP_LATCH;
            end
            S_DISPATCH:
            begin
                w.cond   = C_SHOW;
                w.target = S_SHOW;
            end
            S_CHECK:
            begin
                w.cond   = C_SKIP;
                w.target = S_FETCH;
            end
            S_DIFF:
            begin
                w.op     = OP_DIFF;
                w.cond   = C_HIDE;
                w.target = S_HIDE;
            end
            S_SQX:
            begin
                w.op = OP_SQX;
            end
            S_SQY:
            begin
                w.op = OP_SQY;
            end
            S_CINIT:
            begin
                w.op     = OP_CINIT;
                w.cond   = C_INSIDE;
                w.target = S_CMP;
            end
            S_CSTEP:
            begin
                w.op     = OP_CSTEP;
                w.cond   = C_MORE;
                w.target = S_CSTEP;
            end
            S_SCALE:
            begin
                w.op = OP_SCALE;
            end
            S_INDEX:
            begin
                w.op = OP_INDEX;
            end
            S_CMP:
            begin
                w.cond   = C_SAME;
                w.target = S_FETCH;
            end
            S_HOVER:
            begin
                w.emit = 1'b1;
                w.op   = OP_HOVER;
                w.cond = C_ALWAYS;
            end
            S_HIDE:
            begin
                w.emit = 1'b1;
                w.op   = OP_HIDE;
                w.cond = C_ALWAYS;
            end
            S_SHOW:
            begin
                w.emit = 1'b1;
                w.op   = OP_SHOW;
                w.cond = C_ALWAYS;
            end
            default:
            begin
                w.cond = C_ALWAYS;
            end
        endcase
        return w;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_BITS-1:0] atan_turn(input logic [SH_BITS-1:0] i);
        logic [Z_BITS-1:0] t;
        case (i)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2F9;
            5'd15:   t = 32'h0000517C;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A2F;
            5'd19:   t = 32'h00000517;
            5'd20:   t = 32'h0000028B;
            5'd21:   t = 32'h00000145;
            5'd22:   t = 32'h000000A2;
            5'd23:   t = 32'h00000051;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/rss_if.sv
// Item, result and configuration channel interfaces of the sector selector.
`timescale 1ns / 1ps
`default_nettype none

interface rss_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [rss_pkg::CMD_BITS-1:0]          cmd;
    logic signed [rss_pkg::COORD_BITS-1:0] cursor_x;
    logic signed [rss_pkg::COORD_BITS-1:0] cursor_y;

    modport source (output valid, output cmd, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cmd, input cursor_x, input cursor_y, output ready);
endinterface

interface rss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rss_pkg::EV_BITS-1:0]  event_res;
    logic                         hover_valid;
    logic [rss_pkg::IDX_BITS-1:0] hover_index;
    logic                         selected;
    logic [rss_pkg::IDX_BITS-1:0] selected_index;

    modport source (output valid, output event_res, output hover_valid, output hover_index,
                    output selected, output selected_index, input ready);
    modport sink   (input valid, input event_res, input hover_valid, input hover_index,
                    input selected, input selected_index, output ready);
endinterface

interface rss_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rss_pkg::REG_IDX_BITS-1:0] reg_index;
    logic [rss_pkg::MASK_BITS-1:0]    data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

>>> design/rss_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module rss_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_busy,
    input  rss_pkg::stat_t stat,
    output logic           in_ready,
    output rss_pkg::ctl_t  ctl
);

    rss_pkg::step_t  step_reg;
    rss_pkg::step_t  step_next;
    rss_pkg::ucode_t cw;
    logic            advance;
    logic            take;

    always_comb
    begin
        cw       = rss_pkg::ucode(step_reg);
        in_ready = cw.wait_in;
        advance  = (!cw.wait_in || in_valid) && (!cw.emit || !out_busy);

        case (cw.cond)
            rss_pkg::C_NEXT:   take = 1'b0;
            rss_pkg::C_ALWAYS: take = 1'b1;
            rss_pkg::C_SHOW:   take = stat.cmd_show;
            rss_pkg::C_SKIP:   take = stat.skip;
            rss_pkg::C_HIDE:   take = stat.cmd_hide;
            rss_pkg::C_INSIDE: take = stat.in_dead;
            rss_pkg::C_MORE:   take = stat.more;
            rss_pkg::C_SAME:   take = stat.same;
            default:           take = 1'b0;
        endcase

        if (!advance)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end

        ctl.exec = advance;
        ctl.load = advance && cw.emit;
        ctl.op   = cw.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rss_pkg::S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> design/rss_dp.sv
// Datapath: config registers, menu state, squarer, CORDIC unit and sector scaling.
`timescale 1ns / 1ps
`default_nettype none

module rss_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rss_pkg::ctl_t                         ctl,
    input  logic [rss_pkg::CMD_BITS-1:0]          cmd,
    input  logic signed [rss_pkg::COORD_BITS-1:0] cursor_x,
    input  logic signed [rss_pkg::COORD_BITS-1:0] cursor_y,
    input  logic                                  cfg_we,
    input  logic [rss_pkg::REG_IDX_BITS-1:0]      cfg_index,
    input  logic [rss_pkg::MASK_BITS-1:0]         cfg_data,
    output rss_pkg::stat_t                        stat,
    output rss_pkg::res_t                         res
);

    localparam int CB  = rss_pkg::CORD_BITS;
    localparam int DB  = rss_pkg::DIFF_BITS;
    localparam int QB  = rss_pkg::SQ_BITS;
    localparam int SB  = rss_pkg::SCALE_BITS;
    localparam int AB  = rss_pkg::ANGLE_BITS;
    localparam int ZB  = rss_pkg::Z_BITS;
    localparam int NB  = rss_pkg::CNT_BITS;
    localparam int IB  = rss_pkg::IDX_BITS;

    // configuration
    logic [rss_pkg::DZ_BITS-1:0]   dz_reg;
    logic [NB-1:0]                 cnt_reg;
    logic [rss_pkg::MASK_BITS-1:0] mask_reg;

    // menu state
    logic                                  open_reg;
    logic                                  hovering_reg;
    logic [IB-1:0]                         hovered_reg;
    logic signed [rss_pkg::COORD_BITS-1:0] ctr_x_reg;
    logic signed [rss_pkg::COORD_BITS-1:0] ctr_y_reg;

    // working registers
    logic [rss_pkg::CMD_BITS-1:0]          cmd_reg;
    logic signed [rss_pkg::COORD_BITS-1:0] x_reg;
    logic signed [rss_pkg::COORD_BITS-1:0] y_reg;
    logic signed [DB-1:0]                  dx_reg;
    logic signed [DB-1:0]                  dy_reg;
    logic [QB-1:0]                         acc_reg;
    logic [rss_pkg::RSQ_BITS-1:0]          rsq_reg;
    logic signed [CB-1:0]                  cx_reg;
    logic signed [CB-1:0]                  cy_reg;
    logic [ZB-1:0]                         z_reg;
    logic [rss_pkg::ITER_BITS-1:0]         iter_reg;
    logic [SB-1:0]                         scale_reg;
    logic                                  nv_reg;
    logic [IB-1:0]                         ni_reg;

    logic [NB-1:0]             n_eff;
    logic [DB-1:0]             ax;
    logic [DB-1:0]             ay;
    logic [DB-1:0]             mul_in;
    logic [QB-1:0]             sq;
    logic [SB-1:0]             idx_sum;
    logic [NB-1:0]             idx_raw;
    logic                      sel;
    logic [rss_pkg::SH_BITS-1:0] sh0;
    logic [rss_pkg::SH_BITS-1:0] sh1;
    logic signed [CB-1:0]      x1;
    logic signed [CB-1:0]      y1;
    logic signed [CB-1:0]      x2;
    logic signed [CB-1:0]      y2;
    logic [ZB-1:0]             z1;
    logic [ZB-1:0]             z2;

    always_comb
    begin
        n_eff = (cnt_reg > NB'(rss_pkg::MAX_ITEMS)) ? NB'(rss_pkg::MAX_ITEMS) : cnt_reg;
        ax     = dx_reg[DB-1] ? DB'(-dx_reg) : DB'(dx_reg);
        ay     = dy_reg[DB-1] ? DB'(-dy_reg) : DB'(dy_reg);
        mul_in = (ctl.op == rss_pkg::OP_SQY) ? ay : ax;
        sq     = QB'(mul_in) * QB'(mul_in);

        idx_sum = scale_reg + SB'(1 << (AB - 1));
        idx_raw = idx_sum[SB-1:AB];

        sel = hovering_reg && ({1'b0, hovered_reg} < n_eff) && mask_reg[hovered_reg];
    end

    // two chained vectoring iterations
    always_comb
    begin
        sh0 = {iter_reg, 1'b0};
        sh1 = {iter_reg, 1'b1};
        if (!cy_reg[CB-1])
        begin
            x1 = cx_reg + (cy_reg >>> sh0);
            y1 = cy_reg - (cx_reg >>> sh0);
            z1 = z_reg + rss_pkg::atan_turn(sh0);
        end
        else
        begin
            x1 = cx_reg - (cy_reg >>> sh0);
            y1 = cy_reg + (cx_reg >>> sh0);
            z1 = z_reg - rss_pkg::atan_turn(sh0);
        end
        if (!y1[CB-1])
        begin
            x2 = x1 + (y1 >>> sh1);
            y2 = y1 - (x1 >>> sh1);
            z2 = z1 + rss_pkg::atan_turn(sh1);
        end
        else
        begin
            x2 = x1 - (y1 >>> sh1);
            y2 = y1 + (x1 >>> sh1);
            z2 = z1 - rss_pkg::atan_turn(sh1);
        end
    end

    always_comb
    begin
        stat.cmd_show = (cmd_reg == rss_pkg::CMD_SHOW);
        stat.cmd_hide = (cmd_reg == rss_pkg::CMD_HIDE);
        stat.skip     = !open_reg || !((cmd_reg == rss_pkg::CMD_MOVE) ||
                                       (cmd_reg == rss_pkg::CMD_HIDE));
        stat.in_dead  = (n_eff == '0) || (acc_reg < QB'(rsq_reg));
        stat.more     = (iter_reg != rss_pkg::ITER_LAST);
        stat.same     = (nv_reg == hovering_reg) && (!nv_reg || (ni_reg == hovered_reg));
    end

    always_comb
    begin
        res = '0;
        case (ctl.op)
            rss_pkg::OP_SHOW:
            begin
                res.event_res = rss_pkg::EV_SHOW;
            end
            rss_pkg::OP_HOVER:
            begin
                res.event_res   = rss_pkg::EV_HOVER;
                res.hover_valid = nv_reg;
                res.hover_index = nv_reg ? ni_reg : '0;
            end
            rss_pkg::OP_HIDE:
            begin
                res.event_res      = rss_pkg::EV_HIDE;
                res.selected       = sel;
                res.selected_index = sel ? hovered_reg : '0;
            end
            default:
            begin
                res.event_res = rss_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg       <= rss_pkg::DZ_RESET;
            cnt_reg      <= rss_pkg::CNT_RESET;
            mask_reg     <= rss_pkg::MASK_RESET;
            open_reg     <= 1'b0;
            hovering_reg <= 1'b0;
            hovered_reg  <= '0;
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rss_pkg::REG_DEADZONE: dz_reg   <= cfg_data[rss_pkg::DZ_BITS-1:0];
                    rss_pkg::REG_COUNT:    cnt_reg  <= cfg_data[NB-1:0];
                    rss_pkg::REG_MASK:     mask_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (ctl.exec)
            begin
                case (ctl.op)
                    rss_pkg::OP_SHOW:
                    begin
                        ctr_x_reg    <= x_reg;
                        ctr_y_reg    <= y_reg;
                        open_reg     <= 1'b1;
                        hovering_reg <= 1'b0;
                        hovered_reg  <= '0;
                    end
                    rss_pkg::OP_HOVER:
                    begin
                        hovering_reg <= nv_reg;
                        hovered_reg  <= ni_reg;
                    end
                    rss_pkg::OP_HIDE:
                    begin
                        open_reg     <= 1'b0;
                        hovering_reg <= 1'b0;
                        hovered_reg  <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            case (ctl.op)
                rss_pkg::OP_LATCH:
                begin
                    cmd_reg <= cmd;
                    x_reg   <= cursor_x;
                    y_reg   <= cursor_y;
                end
                rss_pkg::OP_DIFF:
                begin
                    dx_reg  <= DB'(x_reg) - DB'(ctr_x_reg);
                    dy_reg  <= DB'(y_reg) - DB'(ctr_y_reg);
                    rsq_reg <= rss_pkg::RSQ_BITS'(dz_reg) * rss_pkg::RSQ_BITS'(dz_reg);
                end
                rss_pkg::OP_SQX:
                begin
                    acc_reg <= sq;
                end
                rss_pkg::OP_SQY:
                begin
                    acc_reg <= acc_reg + sq;
                end
                rss_pkg::OP_CINIT:
                begin
                    // x = -dy, y = dx; a vector with x < 0 is turned half a turn
                    if (!dy_reg[DB-1] && (dy_reg != '0))
                    begin
                        cx_reg <= CB'(dy_reg);
                        cy_reg <= -CB'(dx_reg);
                        z_reg  <= {1'b1, {(ZB-1){1'b0}}};
                    end
                    else
                    begin
                        cx_reg <= -CB'(dy_reg);
                        cy_reg <= CB'(dx_reg);
                        z_reg  <= '0;
                    end
                    iter_reg <= '0;
                    nv_reg   <= 1'b0;
                    ni_reg   <= '0;
                end
                rss_pkg::OP_CSTEP:
                begin
                    cx_reg   <= x2;
                    cy_reg   <= y2;
                    z_reg    <= z2;
                    iter_reg <= iter_reg + 1'b1;
                end
                rss_pkg::OP_SCALE:
                begin
                    scale_reg <= SB'(z_reg[ZB-1:ZB-AB]) * SB'(n_eff);
                end
                rss_pkg::OP_INDEX:
                begin
                    nv_reg <= 1'b1;
                    ni_reg <= (idx_raw >= n_eff) ? '0 : idx_raw[IB-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/radial_sector_selector.sv
// Top level of the radial sector selector: sequencer, datapath and result register.
//
//  channel   dir   handshake      payload
//  req       in    valid/ready    cmd, cursor_x, cursor_y
//  rsp       out   valid/ready    event_res, hover_valid, hover_index, selected, selected_index
//  cfg       in    valid/ready    reg_index, data (ready always high)
//
// One item at a time. A move runs the CORDIC loop, two vectoring iterations per cycle,
// and gives a result only when the hover changes; inside the deadzone it skips the loop.
// A result sits in the output register while the next item is taken; only
// the step that produces the following result stalls on a full register.
// Reset is asynchronous and clears control state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module radial_sector_selector (
    input  logic      clk,
    input  logic      rst_n,
    rss_req_if.sink   req,
    rss_rsp_if.source rsp,
    rss_cfg_if.sink   cfg
);

    rss_pkg::ctl_t  ctl;
    rss_pkg::stat_t stat;
    rss_pkg::res_t  load_res;
    rss_pkg::res_t  res_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_busy;
    logic           in_ready;

    assign out_busy  = out_valid_reg && !rsp.ready;
    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    rss_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .out_busy (out_busy),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    rss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (req.cmd),
        .cursor_x  (req.cursor_x),
        .cursor_y  (req.cursor_y),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.reg_index),
        .cfg_data  (cfg.data),
        .stat      (stat),
        .res       (load_res)
    );

    always_comb
    begin
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            res_reg <= load_res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.event_res      = res_reg.event_res;
    assign rsp.hover_valid    = res_reg.hover_valid;
    assign rsp.hover_index    = res_reg.hover_index;
    assign rsp.selected       = res_reg.selected;
    assign rsp.selected_index = res_reg.selected_index;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !out_busy)
        else $error("result register overwritten while pending");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item taken while one is in work");

    a_sel_on_hide: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && load_res.selected) |-> (load_res.event_res == rss_pkg::EV_HIDE))
        else $error("selection reported outside hide");

    a_hover_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && load_res.hover_valid) |-> (load_res.event_res == rss_pkg::EV_HOVER))
        else $error("hover reported outside hover change");

endmodule

`default_nettype wire
